[sv/decimating_power_energy_meter_defines.svh]
// Assertion macros for the decimating power and energy meter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DECIMATING_POWER_ENERGY_METER_DEFINES_SVH
`define DECIMATING_POWER_ENERGY_METER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DPEM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DPEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dpem_pkg.sv]
// Shared types, constants and helper functions of the decimating power and energy meter.
// Has no dependencies; every other module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package dpem_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 7;
    localparam int MAG_W    = 22;
    localparam int RECIP_W  = 23;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int POS_W    = SAMPLE_W - 1;
    localparam int SQ_W     = 2 * POS_W;
    localparam int SCALED_W = SQ_W + COUNT_W;
    localparam int CHARGE_W = 48;
    localparam int ENERGY_W = 63;
    localparam int CINC_W   = POS_W + COUNT_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int IN_W     = 2 * SAMPLE_W;
    localparam int OUT_W    = 144;

    // Reciprocals for exact truncating division of magnitudes below 2^22.
    localparam logic [RECIP_W-1:0] DIV10_RECIP  = 23'd3355444;
    localparam int                 DIV10_SHIFT  = 25;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 23'd5368710;
    localparam int                 DIV100_SHIFT = 29;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // Register word index taken from paddr[2].
    localparam logic REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_N1   = 2'd0,
        MODE_N10  = 2'd1,
        MODE_N100 = 2'd2
    } mode_t;

    typedef struct packed {
        logic                       valid;
        logic                       result;
        logic                       clear;
        mode_t                      mode;
        logic signed [SUM_W-1:0]    shunt_sum;
        logic signed [SUM_W-1:0]    bus_sum;
    } run_t;

    typedef struct packed {
        logic                       valid;
        logic                       result;
        logic                       clear;
        mode_t                      mode;
        logic signed [SAMPLE_W-1:0] avg_shunt;
        logic signed [SAMPLE_W-1:0] avg_bus;
        logic [POS_W-1:0]           pos_shunt;
        logic [POS_W-1:0]           pos_bus;
    } avg_t;

    function automatic logic [COUNT_W-1:0] run_len(input mode_t mode);
        logic [COUNT_W-1:0] len;
        case (mode)
            MODE_N10:  len = 7'd10;
            MODE_N100: len = 7'd100;
            default:   len = 7'd1;
        endcase
        return len;
    endfunction

    // Multiplies by the run length with shifts and adds.
    function automatic logic [SCALED_W-1:0] scale_by_run(input logic [SQ_W-1:0] x,
                                                         input mode_t mode);
        logic [SCALED_W-1:0] xe;
        logic [SCALED_W-1:0] y;
        xe = SCALED_W'(x);
        case (mode)
            MODE_N10:  y = (xe << 3) + (xe << 1);
            MODE_N100: y = (xe << 6) + (xe << 5) + (xe << 2);
            default:   y = xe;
        endcase
        return y;
    endfunction

endpackage

`default_nettype wire

[sv/decimating_power_energy_meter.sv]
// Decimating power and energy meter: top level with stream ports and the mode register.
// Depends on dpem_pkg, dpem_boxcar, dpem_recip_div and dpem_totals.
// Result path: run register, divider stages, then product, scaling and result registers.
// Throughput: one item per cycle; the whole pipeline holds while a result waits to be taken.
// Reset: asynchronous, clears the mode, the partial run, both totals and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module decimating_power_energy_meter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dpem_pkg::IN_W-1:0]      s_tdata,   // shunt_sample, bus_sample
    input  logic                           s_tuser,   // clear_totals
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dpem_pkg::OUT_W-1:0]     m_tdata,   // avg_shunt, avg_bus, charge_total,
                                                      // energy_total, one zero pad bit
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpem_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpem_pkg::PDATA_W-1:0]   pwdata,
    output logic [dpem_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import dpem_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       cfg_write;
    logic       cfg_clear;
    mode_t      run_mode;
    logic       advance;
    logic       accept;

    run_t       run;
    avg_t       avg;

    logic signed [SAMPLE_W-1:0] avg_shunt;
    logic signed [SAMPLE_W-1:0] avg_bus;
    logic [CHARGE_W-1:0]        charge_total;
    logic [ENERGY_W-1:0]        energy_total;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_write && (paddr[2] == REG_MODE);
    assign prdata    = (paddr[2] == REG_MODE) ? PDATA_W'(mode_reg) : '0;

    always_comb
    begin
        mode_next = cfg_clear ? pwdata[1:0] : mode_reg;
        case (mode_reg)
            MODE_N10:  run_mode = MODE_N10;
            MODE_N100: run_mode = MODE_N100;
            default:   run_mode = MODE_N1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_N1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    dpem_boxcar u_boxcar (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .accept       (accept),
        .cfg_clear    (cfg_clear),
        .mode         (run_mode),
        .shunt_sample (s_tdata[SAMPLE_W-1:0]),
        .bus_sample   (s_tdata[IN_W-1:SAMPLE_W]),
        .clear_totals (s_tuser),
        .run          (run)
    );

    dpem_recip_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .run     (run),
        .avg     (avg)
    );

    dpem_totals u_totals (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .avg          (avg),
        .out_valid    (m_tvalid),
        .avg_shunt    (avg_shunt),
        .avg_bus      (avg_bus),
        .charge_total (charge_total),
        .energy_total (energy_total)
    );

    assign m_tdata = {1'b0, energy_total, charge_total, avg_bus, avg_shunt};

endmodule

`default_nettype wire

[sv/dpem_boxcar.sv]
// Boxcar run accumulator: sums a run's samples, passes each item on, flags run ends.
// Depends on dpem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpem_boxcar (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                accept,
    input  logic                                cfg_clear,
    input  dpem_pkg::mode_t                     mode,
    input  logic signed [dpem_pkg::SAMPLE_W-1:0] shunt_sample,
    input  logic signed [dpem_pkg::SAMPLE_W-1:0] bus_sample,
    input  logic                                clear_totals,
    output dpem_pkg::run_t                      run
);
    import dpem_pkg::*;

    logic signed [SUM_W-1:0] shunt_sum_reg, shunt_sum_next;
    logic signed [SUM_W-1:0] bus_sum_reg, bus_sum_next;
    logic [COUNT_W-1:0]      run_count_reg, run_count_next;
    run_t                    run_reg, run_next;

    logic signed [SUM_W-1:0] shunt_acc;
    logic signed [SUM_W-1:0] bus_acc;
    logic [COUNT_W-1:0]      count_inc;
    logic                    run_done;

    always_comb
    begin
        shunt_acc = shunt_sum_reg + SUM_W'(shunt_sample);
        bus_acc   = bus_sum_reg + SUM_W'(bus_sample);
        count_inc = run_count_reg + 7'd1;
        run_done  = (count_inc >= run_len(mode));

        shunt_sum_next = shunt_sum_reg;
        bus_sum_next   = bus_sum_reg;
        run_count_next = run_count_reg;
        run_next       = run_reg;

        if (cfg_clear)
        begin
            shunt_sum_next = '0;
            bus_sum_next   = '0;
            run_count_next = '0;
        end
        else if (accept)
        begin
            if (run_done)
            begin
                shunt_sum_next = '0;
                bus_sum_next   = '0;
                run_count_next = '0;
            end
            else
            begin
                shunt_sum_next = shunt_acc;
                bus_sum_next   = bus_acc;
                run_count_next = count_inc;
            end
        end

        if (advance)
        begin
            run_next.valid     = accept;
            run_next.result    = accept && run_done;
            run_next.clear     = clear_totals;
            run_next.mode      = mode;
            run_next.shunt_sum = shunt_acc;
            run_next.bus_sum   = bus_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shunt_sum_reg <= '0;
            bus_sum_reg   <= '0;
            run_count_reg <= '0;
            run_reg       <= '0;
        end
        else
        begin
            shunt_sum_reg <= shunt_sum_next;
            bus_sum_reg   <= bus_sum_next;
            run_count_reg <= run_count_next;
            run_reg       <= run_next;
        end
    end

    assign run = run_reg;

endmodule

`default_nettype wire

[sv/dpem_recip_div.sv]
// Two-stage divider by the run length using reciprocal multiplication, truncating toward zero.
// Depends on dpem_pkg; fed by dpem_boxcar.
`timescale 1ns / 1ps
`default_nettype none

module dpem_recip_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  dpem_pkg::run_t run,
    output dpem_pkg::avg_t avg
);
    import dpem_pkg::*;

    logic               valid_reg, valid_next;
    logic               result_reg, result_next;
    logic               clear_reg, clear_next;
    mode_t              mode_reg, mode_next;
    logic               neg_s_reg, neg_s_next;
    logic               neg_b_reg, neg_b_next;
    logic [MAG_W-1:0]   mag_s_reg, mag_s_next;
    logic [MAG_W-1:0]   mag_b_reg, mag_b_next;
    logic [PROD_W-1:0]  prod_s_reg, prod_s_next;
    logic [PROD_W-1:0]  prod_b_reg, prod_b_next;
    avg_t               avg_reg, avg_next;

    logic [RECIP_W-1:0]  recip;
    logic [SAMPLE_W-1:0] q_s;
    logic [SAMPLE_W-1:0] q_b;

    always_comb
    begin
        recip = (run.mode == MODE_N100) ? DIV100_RECIP : DIV10_RECIP;

        valid_next  = valid_reg;
        result_next = result_reg;
        clear_next  = clear_reg;
        mode_next   = mode_reg;
        neg_s_next  = neg_s_reg;
        neg_b_next  = neg_b_reg;
        mag_s_next  = mag_s_reg;
        mag_b_next  = mag_b_reg;
        prod_s_next = prod_s_reg;
        prod_b_next = prod_b_reg;

        if (advance)
        begin
            valid_next  = run.valid;
            result_next = run.result;
            clear_next  = run.clear;
            mode_next   = run.mode;
            neg_s_next  = run.shunt_sum[SUM_W-1];
            neg_b_next  = run.bus_sum[SUM_W-1];
            mag_s_next  = MAG_W'(run.shunt_sum[SUM_W-1] ? -run.shunt_sum : run.shunt_sum);
            mag_b_next  = MAG_W'(run.bus_sum[SUM_W-1] ? -run.bus_sum : run.bus_sum);
            prod_s_next = mag_s_next * recip;
            prod_b_next = mag_b_next * recip;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_N10:
            begin
                q_s = prod_s_reg[DIV10_SHIFT +: SAMPLE_W];
                q_b = prod_b_reg[DIV10_SHIFT +: SAMPLE_W];
            end
            MODE_N100:
            begin
                q_s = prod_s_reg[DIV100_SHIFT +: SAMPLE_W];
                q_b = prod_b_reg[DIV100_SHIFT +: SAMPLE_W];
            end
            default:
            begin
                q_s = mag_s_reg[SAMPLE_W-1:0];
                q_b = mag_b_reg[SAMPLE_W-1:0];
            end
        endcase

        avg_next = avg_reg;
        if (advance)
        begin
            avg_next.valid     = valid_reg;
            avg_next.result    = result_reg;
            avg_next.clear     = clear_reg;
            avg_next.mode      = mode_reg;
            avg_next.avg_shunt = neg_s_reg ? -q_s : q_s;
            avg_next.avg_bus   = neg_b_reg ? -q_b : q_b;
            avg_next.pos_shunt = neg_s_reg ? '0 : q_s[POS_W-1:0];
            avg_next.pos_bus   = neg_b_reg ? '0 : q_b[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            avg_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            avg_reg   <= avg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        clear_reg  <= clear_next;
        mode_reg   <= mode_next;
        neg_s_reg  <= neg_s_next;
        neg_b_reg  <= neg_b_next;
        mag_s_reg  <= mag_s_next;
        mag_b_reg  <= mag_b_next;
        prod_s_reg <= prod_s_next;
        prod_b_reg <= prod_b_next;
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

[sv/dpem_totals.sv]
// Charge and energy totals: products scaled by run length, saturating accumulation, result register.
// Depends on dpem_pkg; fed by dpem_recip_div.
`timescale 1ns / 1ps
`default_nettype none

module dpem_totals (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  dpem_pkg::avg_t                       avg,
    output logic                                 out_valid,
    output logic signed [dpem_pkg::SAMPLE_W-1:0] avg_shunt,
    output logic signed [dpem_pkg::SAMPLE_W-1:0] avg_bus,
    output logic [dpem_pkg::CHARGE_W-1:0]        charge_total,
    output logic [dpem_pkg::ENERGY_W-1:0]        energy_total
);
    import dpem_pkg::*;

    // Product stage
    logic                       p_valid_reg, p_valid_next;
    logic                       p_result_reg, p_result_next;
    logic                       p_clear_reg, p_clear_next;
    mode_t                      p_mode_reg, p_mode_next;
    logic signed [SAMPLE_W-1:0] p_avg_s_reg, p_avg_s_next;
    logic signed [SAMPLE_W-1:0] p_avg_b_reg, p_avg_b_next;
    logic [CINC_W-1:0]          p_cinc_reg, p_cinc_next;
    logic [SQ_W-1:0]            p_sq_reg, p_sq_next;

    // Scaling stage
    logic                       e_valid_reg, e_valid_next;
    logic                       e_result_reg, e_result_next;
    logic                       e_clear_reg, e_clear_next;
    logic signed [SAMPLE_W-1:0] e_avg_s_reg, e_avg_s_next;
    logic signed [SAMPLE_W-1:0] e_avg_b_reg, e_avg_b_next;
    logic [CINC_W-1:0]          e_cinc_reg, e_cinc_next;
    logic [SCALED_W-1:0]        e_einc_reg, e_einc_next;

    // Accumulators and result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] avg_s_reg, avg_s_next;
    logic signed [SAMPLE_W-1:0] avg_b_reg, avg_b_next;
    logic [CHARGE_W-1:0]        charge_reg, charge_next;
    logic [ENERGY_W-1:0]        energy_reg, energy_next;

    logic [CHARGE_W-1:0]        charge_base;
    logic [ENERGY_W-1:0]        energy_base;
    logic [CHARGE_W:0]          charge_sum;
    logic [ENERGY_W:0]          energy_sum;

    always_comb
    begin
        p_valid_next  = p_valid_reg;
        p_result_next = p_result_reg;
        p_clear_next  = p_clear_reg;
        p_mode_next   = p_mode_reg;
        p_avg_s_next  = p_avg_s_reg;
        p_avg_b_next  = p_avg_b_reg;
        p_cinc_next   = p_cinc_reg;
        p_sq_next     = p_sq_reg;
        if (advance)
        begin
            p_valid_next  = avg.valid;
            p_result_next = avg.result;
            p_clear_next  = avg.clear;
            p_mode_next   = avg.mode;
            p_avg_s_next  = avg.avg_shunt;
            p_avg_b_next  = avg.avg_bus;
            p_cinc_next   = CINC_W'(scale_by_run(SQ_W'(avg.pos_shunt), avg.mode));
            p_sq_next     = avg.pos_shunt * avg.pos_bus;
        end
    end

    always_comb
    begin
        e_valid_next  = e_valid_reg;
        e_result_next = e_result_reg;
        e_clear_next  = e_clear_reg;
        e_avg_s_next  = e_avg_s_reg;
        e_avg_b_next  = e_avg_b_reg;
        e_cinc_next   = e_cinc_reg;
        e_einc_next   = e_einc_reg;
        if (advance)
        begin
            e_valid_next  = p_valid_reg;
            e_result_next = p_result_reg;
            e_clear_next  = p_clear_reg;
            e_avg_s_next  = p_avg_s_reg;
            e_avg_b_next  = p_avg_b_reg;
            e_cinc_next   = p_cinc_reg;
            e_einc_next   = scale_by_run(p_sq_reg, p_mode_reg);
        end
    end

    always_comb
    begin
        charge_base = e_clear_reg ? '0 : charge_reg;
        energy_base = e_clear_reg ? '0 : energy_reg;
        charge_sum  = {1'b0, charge_base} + (CHARGE_W + 1)'(e_cinc_reg);
        energy_sum  = {1'b0, energy_base} + (ENERGY_W + 1)'(e_einc_reg);

        out_valid_next = out_valid_reg;
        avg_s_next     = avg_s_reg;
        avg_b_next     = avg_b_reg;
        charge_next    = charge_reg;
        energy_next    = energy_reg;

        if (advance)
        begin
            out_valid_next = e_valid_reg && e_result_reg;
            if (e_valid_reg)
            begin
                if (e_result_reg)
                begin
                    avg_s_next  = e_avg_s_reg;
                    avg_b_next  = e_avg_b_reg;
                    charge_next = charge_sum[CHARGE_W] ? CHARGE_MAX : charge_sum[CHARGE_W-1:0];
                    energy_next = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
                end
                else
                begin
                    charge_next = charge_base;
                    energy_next = energy_base;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            charge_reg    <= '0;
            energy_reg    <= '0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            e_valid_reg   <= e_valid_next;
            out_valid_reg <= out_valid_next;
            charge_reg    <= charge_next;
            energy_reg    <= energy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_result_reg <= p_result_next;
        p_clear_reg  <= p_clear_next;
        p_mode_reg   <= p_mode_next;
        p_avg_s_reg  <= p_avg_s_next;
        p_avg_b_reg  <= p_avg_b_next;
        p_cinc_reg   <= p_cinc_next;
        p_sq_reg     <= p_sq_next;
        e_result_reg <= e_result_next;
        e_clear_reg  <= e_clear_next;
        e_avg_s_reg  <= e_avg_s_next;
        e_avg_b_reg  <= e_avg_b_next;
        e_cinc_reg   <= e_cinc_next;
        e_einc_reg   <= e_einc_next;
        avg_s_reg    <= avg_s_next;
        avg_b_reg    <= avg_b_next;
    end

    assign out_valid    = out_valid_reg;
    assign avg_shunt    = avg_s_reg;
    assign avg_bus      = avg_b_reg;
    assign charge_total = charge_reg;
    assign energy_total = energy_reg;

endmodule

`default_nettype wire

[sv/dpem_checker.sv]
// Port-level checks of the decimating power and energy meter, bound to its top level.
// Depends on dpem_pkg and decimating_power_energy_meter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "decimating_power_energy_meter_defines.svh"

module dpem_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dpem_pkg::OUT_W-1:0]   m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [dpem_pkg::PADDR_W-1:0] paddr,
    input logic [dpem_pkg::PDATA_W-1:0] pwdata,
    input logic [dpem_pkg::PDATA_W-1:0] prdata
);
    import dpem_pkg::*;

    `DPEM_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
    `DPEM_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input accepted while result stalled")
    `DPEM_ASSERT_NEXT(a_mode_readback, psel && penable && pwrite && (paddr[2] == REG_MODE), (paddr[2] != REG_MODE) || (prdata[1:0] == $past(pwdata[1:0])), "mode register reads back wrong")
    `DPEM_ASSERT_SAME(a_energy_needs_charge, m_tvalid && (m_tdata[79:32] == 48'd0), m_tdata[142:80] == 63'd0, "energy grew without charge")

endmodule

bind decimating_power_energy_meter dpem_checker u_dpem_checker (.*);

`default_nettype wire
